### rtl/core/esfr_pkg.sv
// ----------------------------------------------------------------------------
// esfr_pkg
// Shared types and constants of the elastic stereo resampler core.
// ----------------------------------------------------------------------------
`default_nettype none

package esfr_pkg;

  localparam int TARGET_W = 11;
  localparam logic [TARGET_W-1:0] TARGET_RESET = 11'd256;
  localparam int MIN_TARGET = 16;
  localparam int MIN_DEPTH = 3;
  localparam int DEV_LIMIT = 10737418;
  localparam int K_DEPTH = 3355;
  localparam int K_RATIO = 4294967;
  localparam int RATIO_DEAD = 1073;
  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
  localparam int CNT_W = 32;

  // register index on the configuration port
  localparam logic REG_TARGET = 1'b0;

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_PULL = 2'd1,
    CMD_TRIM = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
    logic disc;
  } qhead_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DMUL,
    ST_DADD,
    ST_DIV,
    ST_RMUL,
    ST_RUPD,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_PREP,
    ST_HINIT,
    ST_HMUL,
    ST_HACC,
    ST_ADV,
    ST_GAP,
    ST_GAPCHK,
    ST_HIST,
    ST_HIST2,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

### rtl/core/esfr_divider.sv
// ----------------------------------------------------------------------------
// esfr_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module esfr_divider import esfr_pkg::*; #(
  parameter int NW = 45,
  parameter int DW = 19
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output div_stat_t          stat,
  output logic      [NW-1:0] quo
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  logic [DW:0]   rem_sh;
  logic          ge;
  logic [DW:0]   rem_sub;

  always_comb begin
    rem_sh  = {rem_r, quo_r[NW-1]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_sub = rem_sh - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r  <= num;
        rem_r  <= '0;
        den_r  <= den;
        cnt_r  <= CW'(NW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        // shift in one numerator bit, subtract where it fits
        rem_r <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
        quo_r <= {quo_r[NW-2:0], ge};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quo       = quo_r;

endmodule

`default_nettype wire

### rtl/core/esfr_front.sv
// ----------------------------------------------------------------------------
// esfr_front
// Input side: accept words, classify the command, hold them in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none

module esfr_front import esfr_pkg::*; #(
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_command,
  input  wire logic signed [SAMPLE_BITS-1:0] in_left,
  input  wire logic signed [SAMPLE_BITS-1:0] in_right,
  input  wire logic                          in_discontinuity,
  input  wire logic                          pop,
  output qhead_t                             head,
  output logic signed [SAMPLE_BITS-1:0]      head_left,
  output logic signed [SAMPLE_BITS-1:0]      head_right
);

  localparam int QD = 4;
  localparam int QA = $clog2(QD);

  cmd_t                         q_cmd  [QD];
  logic                         q_disc [QD];
  logic signed [SAMPLE_BITS-1:0] q_l   [QD];
  logic signed [SAMPLE_BITS-1:0] q_r   [QD];

  logic [QA:0] wr_r;
  logic [QA:0] rd_r;
  logic        full;
  logic        empty;
  logic        push;
  cmd_t        cls;

  always_comb begin
    case (in_command)
      2'd0:    cls = CMD_PUSH;
      2'd1:    cls = CMD_PULL;
      2'd2:    cls = CMD_TRIM;
      default: cls = CMD_NOP;
    endcase
  end

  assign full     = (wr_r[QA] != rd_r[QA]) && (wr_r[QA-1:0] == rd_r[QA-1:0]);
  assign empty    = wr_r == rd_r;
  assign in_stall = full;
  assign push     = in_valid && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + (QA+1)'(1);
      end
      if (pop && !empty) begin
        rd_r <= rd_r + (QA+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_cmd[wr_r[QA-1:0]]  <= cls;
      q_disc[wr_r[QA-1:0]] <= in_discontinuity;
      q_l[wr_r[QA-1:0]]    <= in_left;
      q_r[wr_r[QA-1:0]]    <= in_right;
    end
  end

  assign head.valid = !empty;
  assign head.cmd   = q_cmd[rd_r[QA-1:0]];
  assign head.disc  = q_disc[rd_r[QA-1:0]];
  assign head_left  = q_l[rd_r[QA-1:0]];
  assign head_right = q_r[rd_r[QA-1:0]];

endmodule

`default_nettype wire

### rtl/core/esfr_engine.sv
// ----------------------------------------------------------------------------
// esfr_engine
// Back end: ring buffer, depth filter, ratio loop and Hermite interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

module esfr_engine import esfr_pkg::*; #(
  parameter int CAPACITY_FRAMES = 4096,
  parameter int SAMPLE_BITS     = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [TARGET_W-1:0]           target,
  input  qhead_t                             head,
  input  wire logic signed [SAMPLE_BITS-1:0] head_left,
  input  wire logic signed [SAMPLE_BITS-1:0] head_right,
  output logic                               pop,
  input  wire logic                          out_stall,
  output logic                               out_valid,
  output logic                               out_accepted,
  output logic signed [SAMPLE_BITS-1:0]      out_left,
  output logic signed [SAMPLE_BITS-1:0]      out_right,
  output logic                               out_discontinuity,
  output logic [$clog2(CAPACITY_FRAMES):0]   out_fill_level,
  output logic [$clog2(CAPACITY_FRAMES):0]   out_peak_fill,
  output logic [30:0]                        out_resample_ratio,
  output logic [CNT_W-1:0]                   out_overrun_count,
  output logic [CNT_W-1:0]                   out_resampled_count
);

  localparam int SB   = SAMPLE_BITS;
  localparam int PW   = $clog2(CAPACITY_FRAMES) + 1;
  localparam int AW   = PW - 1;
  localparam int SDW  = PW + 32;
  localparam int DHW  = SDW + 1 - 23;
  localparam int PRW  = SDW + 14;
  localparam int DENW = TARGET_W + 8;
  localparam int TW   = SB + 5;
  localparam int EW   = (PW > TARGET_W) ? PW : TARGET_W;
  localparam int RT0  = (CAPACITY_FRAMES / 4 < 256) ? CAPACITY_FRAMES / 4 : 256;
  localparam int RST_TGT = (RT0 < MIN_TARGET) ? MIN_TARGET : RT0;
  localparam logic signed [TW:0] SMAX = (TW+1)'((64'sd1 <<< (SB - 1)) - 64'sd1);
  localparam logic signed [TW:0] SMIN = -SMAX - (TW+1)'(1);

  // ring buffer stores
  logic [2*SB-1:0] samp_mem [CAPACITY_FRAMES];
  logic            mark_mem [CAPACITY_FRAMES];
  logic [2*SB-1:0] s_rdata_r;
  logic            m_rdata_r;
  logic            s_we;
  logic [AW-1:0]   s_waddr;
  logic [AW-1:0]   s_raddr;
  logic            m_we;
  logic [AW-1:0]   m_waddr;
  logic            m_wdata;
  logic [AW-1:0]   m_raddr;

  state_t state_r, state_nxt;

  // item in work
  cmd_t                  cmd_r;
  logic                  idisc_r;
  logic signed [SB-1:0]  il_r, ir_r;

  // control state
  logic [PW-1:0]         wp_r, rp_r, peak_r;
  logic [29:0]           phase_r;
  logic signed [31:0]    ratio_r;
  logic [SDW-1:0]        sd_r;
  logic                  hok_r, pend_r;
  logic [CNT_W-1:0]      ovr_r, rsm_r;
  logic signed [SB-1:0]  hl_r, hr_r;

  // per-pull working registers
  logic                  acc_r, disc_r;
  logic [34:0]           plo_r;
  logic signed [DHW+12:0] phi_r;
  logic                  neg_r;
  logic signed [49:0]    rprod_r;
  logic [2*SB-1:0]       cur_r, nx_r, nn_r;
  logic                  cc_r, nc_r, n2c_r;
  logic signed [SB-1:0]  yl_r [4];
  logic signed [SB-1:0]  yr_r [4];
  logic signed [TW-1:0]  ht_r;
  logic signed [TW+20:0] hp_r;
  logic [1:0]            hstep_r;
  logic                  chan_r;
  logic signed [SB-1:0]  resl_r, resr_r;
  logic [2:0]            adv_r, k_r;

  // output register
  logic                  ov_r, oacc_r, odisc_r;
  logic signed [SB-1:0]  ol_r, or_r;
  logic [PW-1:0]         ofill_r, opeak_r;
  logic [30:0]           oratio_r;
  logic [CNT_W-1:0]      oovr_r, orsm_r;

  // divider link
  logic                  div_start;
  div_stat_t             div_stat;
  logic [SDW-1:0]        div_quo;
  logic [SDW-1:0]        num_mag;
  logic [DENW-1:0]       den;

  logic [PW-1:0]         fill;
  logic [EW-1:0]         tcl;
  logic [TARGET_W-1:0]   tgt;
  logic [PW-1:0]         tgt_p;

  assign fill  = wp_r - rp_r;
  always_comb begin
    tcl = EW'(target);
    if (tcl > EW'(CAPACITY_FRAMES / 4)) tcl = EW'(CAPACITY_FRAMES / 4);
    if (tcl < EW'(MIN_TARGET)) tcl = EW'(MIN_TARGET);
  end
  assign tgt   = tcl[TARGET_W-1:0];
  assign tgt_p = PW'(tgt);

  // depth filter arithmetic
  logic signed [SDW:0]   diff;
  logic signed [PRW-1:0] fprod;
  logic signed [SDW:0]   sd_sum;
  logic signed [SDW:0]   num_s;
  logic signed [SDW:0]   num_neg;

  always_comb begin
    diff    = $signed({1'b0, fill, 32'b0}) - $signed({1'b0, sd_r});
    fprod   = $signed({phi_r, 23'b0}) + PRW'($signed({1'b0, plo_r}));
    sd_sum  = $signed({1'b0, sd_r}) + (SDW+1)'($signed(fprod[PRW-1:24]));
    num_s   = sd_sum - $signed({1'b0, tgt_p, 32'b0});
    num_neg = -num_s;
    num_mag = num_s[SDW] ? num_neg[SDW-1:0] : num_s[SDW-1:0];
    den     = {tgt, 8'b0};
  end

  // ratio loop arithmetic
  logic [24:0]           qcl;
  logic signed [24:0]    dev;
  logic signed [31:0]    desired;
  logic signed [31:0]    dr;
  logic signed [49:0]    rrnd;
  logic signed [31:0]    ratio_new;
  logic signed [31:0]    rdist;

  always_comb begin
    qcl       = (div_quo > SDW'(DEV_LIMIT)) ? 25'(DEV_LIMIT) : div_quo[24:0];
    dev       = neg_r ? -$signed(qcl) : $signed(qcl);
    desired   = $signed(ONE_Q30) + 32'(dev);
    dr        = desired - ratio_r;
    rrnd      = rprod_r + 50'sd2147483648;
    ratio_new = ratio_r + 32'($signed(rrnd[49:32]));
    rdist     = ratio_new - $signed(ONE_Q30);
  end

  // Hermite coefficients, both channels
  logic signed [TW-1:0]  c0 [2];
  logic signed [TW-1:0]  c1 [2];
  logic signed [TW-1:0]  c2 [2];
  logic signed [TW-1:0]  c_add;
  logic signed [TW:0]    hacc;
  logic signed [TW+20:0] hrnd;
  logic signed [TW:0]    hres;
  logic signed [SB-1:0]  hsat;
  logic signed [SB-1:0]  y1_sel;

  always_comb begin
    c0[0] = -TW'(yl_r[0]) + 3 * TW'(yl_r[1]) - 3 * TW'(yl_r[2]) + TW'(yl_r[3]);
    c1[0] = 2 * TW'(yl_r[0]) - 5 * TW'(yl_r[1]) + 4 * TW'(yl_r[2]) - TW'(yl_r[3]);
    c2[0] = TW'(yl_r[2]) - TW'(yl_r[0]);
    c0[1] = -TW'(yr_r[0]) + 3 * TW'(yr_r[1]) - 3 * TW'(yr_r[2]) + TW'(yr_r[3]);
    c1[1] = 2 * TW'(yr_r[0]) - 5 * TW'(yr_r[1]) + 4 * TW'(yr_r[2]) - TW'(yr_r[3]);
    c2[1] = TW'(yr_r[2]) - TW'(yr_r[0]);
    c_add  = (hstep_r == 2'd0) ? c1[chan_r] : c2[chan_r];
    hacc   = $signed(hp_r[TW+20:20]) + (TW+1)'(c_add);
    hrnd   = hp_r + $signed({{TW{1'b0}}, 1'b1, 20'b0});
    y1_sel = chan_r ? yr_r[1] : yl_r[1];
    hres   = (TW+1)'($signed(hrnd[TW+20:21])) + (TW+1)'(y1_sel);
    if (hres > SMAX) begin
      hsat = SB'(SMAX);
    end else if (hres < SMIN) begin
      hsat = SB'(SMIN);
    end else begin
      hsat = hres[SB-1:0];
    end
  end

  // phase advance
  logic [32:0] pnext;
  logic        adv_cap;
  always_comb begin
    pnext   = {3'b0, phase_r} + {1'b0, ratio_r[31:0]};
    adv_cap = (PW'(pnext[32:30]) + PW'(2)) > fill;
  end

  logic out_free;
  assign out_free = !ov_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (head.valid) state_nxt = ST_DECODE;
      ST_DECODE: begin
        if (cmd_r == CMD_PULL && fill >= PW'(MIN_DEPTH)) begin
          state_nxt = ST_DMUL;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DMUL:   state_nxt = ST_DADD;
      ST_DADD:   state_nxt = ST_DIV;
      ST_DIV:    if (div_stat.done) state_nxt = ST_RMUL;
      ST_RMUL:   state_nxt = ST_RUPD;
      ST_RUPD:   state_nxt = ST_RD0;
      ST_RD0:    state_nxt = ST_RD1;
      ST_RD1:    state_nxt = ST_RD2;
      ST_RD2:    state_nxt = ST_RD3;
      ST_RD3:    state_nxt = ST_PREP;
      ST_PREP:   state_nxt = ST_HINIT;
      ST_HINIT:  state_nxt = ST_HMUL;
      ST_HMUL:   state_nxt = ST_HACC;
      ST_HACC: begin
        if (hstep_r == 2'd2 && chan_r) begin
          state_nxt = ST_ADV;
        end else begin
          state_nxt = ST_HMUL;
        end
      end
      ST_ADV:    state_nxt = ST_GAP;
      ST_GAP:    state_nxt = (k_r < adv_r) ? ST_GAPCHK : ST_HIST;
      ST_GAPCHK: state_nxt = ST_GAP;
      ST_HIST:   state_nxt = (adv_r != 3'd0) ? ST_HIST2 : ST_DONE;
      ST_HIST2:  state_nxt = ST_DONE;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // memory ports, queue pop, divider start
  always_comb begin
    pop       = 1'b0;
    div_start = 1'b0;
    s_we      = 1'b0;
    s_waddr   = wp_r[AW-1:0];
    s_raddr   = rp_r[AW-1:0];
    m_we      = 1'b0;
    m_waddr   = wp_r[AW-1:0];
    m_wdata   = idisc_r;
    m_raddr   = rp_r[AW-1:0];
    case (state_r)
      ST_IDLE:   pop = head.valid;
      ST_DECODE: begin
        if (cmd_r == CMD_PUSH && fill < PW'(CAPACITY_FRAMES)) begin
          s_we = 1'b1;
          m_we = 1'b1;
        end
      end
      ST_DADD:   div_start = 1'b1;
      ST_RD1: begin
        s_raddr = rp_r[AW-1:0] + AW'(1);
        m_raddr = rp_r[AW-1:0] + AW'(1);
      end
      ST_RD2: begin
        s_raddr = rp_r[AW-1:0] + AW'(2);
        m_raddr = rp_r[AW-1:0] + AW'(2);
      end
      ST_PREP: begin
        m_we    = 1'b1;
        m_waddr = rp_r[AW-1:0];
        m_wdata = 1'b0;
      end
      ST_GAP:    m_raddr = rp_r[AW-1:0] + AW'(k_r);
      ST_GAPCHK: begin
        m_we    = 1'b1;
        m_waddr = rp_r[AW-1:0] + AW'(k_r);
        m_wdata = 1'b0;
      end
      ST_HIST:   s_raddr = rp_r[AW-1:0] + AW'(adv_r) - AW'(1);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (s_we) samp_mem[s_waddr] <= {il_r, ir_r};
    s_rdata_r <= samp_mem[s_raddr];
  end

  always_ff @(posedge clk) begin
    if (m_we) mark_mem[m_waddr] <= m_wdata;
    m_rdata_r <= mark_mem[m_raddr];
  end

  esfr_divider #(
    .NW (SDW),
    .DW (DENW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_mag),
    .den   (den),
    .stat  (div_stat),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wp_r    <= '0;
      rp_r    <= '0;
      phase_r <= '0;
      ratio_r <= $signed(ONE_Q30);
      sd_r    <= {PW'(RST_TGT), 32'b0};
      hok_r   <= 1'b0;
      pend_r  <= 1'b0;
      peak_r  <= PW'(RST_TGT);
      ovr_r   <= '0;
      rsm_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ov_r && !out_stall) ov_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (head.valid) begin
            cmd_r   <= head.cmd;
            idisc_r <= head.disc;
            il_r    <= head_left;
            ir_r    <= head_right;
            acc_r   <= 1'b0;
            disc_r  <= 1'b0;
            resl_r  <= '0;
            resr_r  <= '0;
          end
        end
        ST_DECODE: begin
          case (cmd_r)
            CMD_PUSH: begin
              if (fill >= PW'(CAPACITY_FRAMES)) begin
                if (ovr_r != '1) ovr_r <= ovr_r + CNT_W'(1);
              end else begin
                wp_r  <= wp_r + PW'(1);
                acc_r <= 1'b1;
                if (fill + PW'(1) > peak_r) peak_r <= fill + PW'(1);
              end
            end
            CMD_TRIM: begin
              if (fill > tgt_p) rp_r <= wp_r - tgt_p;
              phase_r <= '0;
              ratio_r <= $signed(ONE_Q30);
              sd_r    <= {tgt_p, 32'b0};
              hok_r   <= 1'b0;
              pend_r  <= 1'b0;
              peak_r  <= tgt_p;
              acc_r   <= 1'b1;
            end
            default: begin
            end
          endcase
        end
        ST_DMUL: begin
          plo_r <= diff[22:0] * 12'd3355;
          phi_r <= $signed(diff[SDW:23]) * $signed(13'sd3355);
        end
        ST_DADD: begin
          sd_r  <= sd_sum[SDW-1:0];
          neg_r <= num_s[SDW];
        end
        ST_RMUL: rprod_r <= $signed(dr[25:0]) * $signed(24'sd4294967);
        ST_RUPD: begin
          ratio_r <= ratio_new;
          if ((rdist > 32'sd1073 || rdist < -32'sd1073) && rsm_r != '1) begin
            rsm_r <= rsm_r + CNT_W'(1);
          end
        end
        ST_RD1: begin
          cur_r <= s_rdata_r;
          cc_r  <= m_rdata_r;
        end
        ST_RD2: begin
          nx_r <= s_rdata_r;
          nc_r <= m_rdata_r;
        end
        ST_RD3: begin
          nn_r  <= s_rdata_r;
          n2c_r <= m_rdata_r;
        end
        ST_PREP: begin
          // a marked frame restarts the interpolation timeline
          yl_r[1] <= $signed(cur_r[2*SB-1:SB]);
          yr_r[1] <= $signed(cur_r[SB-1:0]);
          yl_r[2] <= nc_r ? $signed(cur_r[2*SB-1:SB]) : $signed(nx_r[2*SB-1:SB]);
          yr_r[2] <= nc_r ? $signed(cur_r[SB-1:0]) : $signed(nx_r[SB-1:0]);
          if (nc_r) begin
            yl_r[3] <= $signed(cur_r[2*SB-1:SB]);
            yr_r[3] <= $signed(cur_r[SB-1:0]);
          end else if (n2c_r) begin
            yl_r[3] <= $signed(nx_r[2*SB-1:SB]);
            yr_r[3] <= $signed(nx_r[SB-1:0]);
          end else begin
            yl_r[3] <= $signed(nn_r[2*SB-1:SB]);
            yr_r[3] <= $signed(nn_r[SB-1:0]);
          end
          if (hok_r && !cc_r) begin
            yl_r[0] <= hl_r;
            yr_r[0] <= hr_r;
          end else begin
            yl_r[0] <= $signed(cur_r[2*SB-1:SB]);
            yr_r[0] <= $signed(cur_r[SB-1:0]);
          end
          if (cc_r) begin
            phase_r <= '0;
            hok_r   <= 1'b0;
          end
          disc_r <= pend_r || cc_r;
          pend_r <= 1'b0;
        end
        ST_HINIT: begin
          ht_r    <= c0[0];
          chan_r  <= 1'b0;
          hstep_r <= 2'd0;
        end
        ST_HMUL: hp_r <= ht_r * $signed({1'b0, phase_r[29:10]});
        ST_HACC: begin
          if (hstep_r == 2'd2) begin
            if (chan_r) begin
              resr_r <= hsat;
            end else begin
              resl_r  <= hsat;
              chan_r  <= 1'b1;
              hstep_r <= 2'd0;
              ht_r    <= c0[1];
            end
          end else begin
            ht_r    <= hacc[TW-1:0];
            hstep_r <= hstep_r + 2'd1;
          end
        end
        ST_ADV: begin
          k_r <= 3'd1;
          if (adv_cap) begin
            adv_r   <= 3'(fill - PW'(2));
            phase_r <= '0;
          end else begin
            adv_r   <= pnext[32:30];
            phase_r <= pnext[29:0];
          end
        end
        ST_GAPCHK: begin
          if (m_rdata_r) pend_r <= 1'b1;
          k_r <= k_r + 3'd1;
        end
        ST_HIST2: begin
          hl_r  <= $signed(s_rdata_r[2*SB-1:SB]);
          hr_r  <= $signed(s_rdata_r[SB-1:0]);
          hok_r <= 1'b1;
          rp_r  <= rp_r + PW'(adv_r);
          acc_r <= 1'b1;
        end
        ST_HIST: begin
          if (adv_r == 3'd0) acc_r <= 1'b1;
        end
        ST_DONE: begin
          if (out_free) begin
            ov_r     <= 1'b1;
            oacc_r   <= acc_r;
            ol_r     <= resl_r;
            or_r     <= resr_r;
            odisc_r  <= disc_r;
            ofill_r  <= fill;
            opeak_r  <= peak_r;
            oratio_r <= ratio_r[30:0];
            oovr_r   <= ovr_r;
            orsm_r   <= rsm_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid           = ov_r;
  assign out_accepted        = oacc_r;
  assign out_left            = ol_r;
  assign out_right           = or_r;
  assign out_discontinuity   = odisc_r;
  assign out_fill_level      = ofill_r;
  assign out_peak_fill       = opeak_r;
  assign out_resample_ratio  = oratio_r;
  assign out_overrun_count   = oovr_r;
  assign out_resampled_count = orsm_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill <= PW'(CAPACITY_FRAMES))
    else $error("ring buffer holds more frames than its capacity");

  a_div_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (div_stat.busy || div_stat.done))
    else $error("waiting on a divider that is not running");

  a_ratio_band: assert property (@(posedge clk) disable iff (!rst_n)
    (ratio_r <= $signed(ONE_Q30) + 32'sd10737418) &&
    (ratio_r >= $signed(ONE_Q30) - 32'sd10737418))
    else $error("read ratio left its steering band");

  a_adv_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GAP) |-> (PW'(adv_r) + PW'(2) <= fill))
    else $error("read advance runs past buffered data");

endmodule

`default_nettype wire

### rtl/core/elastic_stereo_fifo_resampler_core.sv
// ----------------------------------------------------------------------------
// elastic_stereo_fifo_resampler_core
// Stereo elastic buffer whose read side resamples to track clock drift.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one command word per handshake, push,
// pull or trim, with a stereo frame and its discontinuity mark for pushes.
// Words land in a four-entry command queue, so the sender keeps going while
// the back end works; in_stall rises only when that queue is full.
// Output channel (out_valid / out_stall): exactly one status word per
// command, in order. A finished word sits in the output register; while the
// receiver stalls it, the back end completes its current command and then
// holds, and the queue keeps taking input until it fills.
// Timing: push, trim, failed pull and unknown commands pass from decode
// straight to the output register. A successful pull is dominated by the
// bit-serial divider of the depth error, one quotient bit per cycle; then
// a single shared multiplier walks the Hermite steps for both channels.
// Reset (rst_n, synchronous): pointers, phase, ratio, depth filter, peak and
// counters return to their start values; the sample store is not cleared.
// Configuration: APB, target_fill at byte address 0, written only when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module elastic_stereo_fifo_resampler_core import esfr_pkg::*; #(
  parameter int CAPACITY_FRAMES = 4096,
  parameter int SAMPLE_BITS     = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // command words
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_command,
  input  wire logic signed [SAMPLE_BITS-1:0] in_left,
  input  wire logic signed [SAMPLE_BITS-1:0] in_right,
  input  wire logic                          in_discontinuity,
  // status words
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_accepted,
  output logic signed [SAMPLE_BITS-1:0]      out_left,
  output logic signed [SAMPLE_BITS-1:0]      out_right,
  output logic                               out_discontinuity,
  output logic [$clog2(CAPACITY_FRAMES):0]   out_fill_level,
  output logic [$clog2(CAPACITY_FRAMES):0]   out_peak_fill,
  output logic [30:0]                        out_resample_ratio,
  output logic [CNT_W-1:0]                   out_overrun_count,
  output logic [CNT_W-1:0]                   out_resampled_count,
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [2:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  logic [TARGET_W-1:0] target_r;
  logic                cfg_wr;

  qhead_t                          head;
  logic signed [SAMPLE_BITS-1:0]   head_left;
  logic signed [SAMPLE_BITS-1:0]   head_right;
  logic                            pop;

  // Zero wait states; only register index zero exists.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= TARGET_RESET;
    end else if (cfg_wr && paddr[2] == REG_TARGET) begin
      target_r <= pwdata[TARGET_W-1:0];
    end
  end

  // Read back the raw register; the clamp is applied only where it is used.
  assign prdata = (paddr[2] == REG_TARGET) ? 32'(target_r) : 32'd0;

  esfr_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_left          (in_left),
    .in_right         (in_right),
    .in_discontinuity (in_discontinuity),
    .pop              (pop),
    .head             (head),
    .head_left        (head_left),
    .head_right       (head_right)
  );

  esfr_engine #(
    .CAPACITY_FRAMES (CAPACITY_FRAMES),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_engine (
    .clk                 (clk),
    .rst_n               (rst_n),
    .target              (target_r),
    .head                (head),
    .head_left           (head_left),
    .head_right          (head_right),
    .pop                 (pop),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .out_accepted        (out_accepted),
    .out_left            (out_left),
    .out_right           (out_right),
    .out_discontinuity   (out_discontinuity),
    .out_fill_level      (out_fill_level),
    .out_peak_fill       (out_peak_fill),
    .out_resample_ratio  (out_resample_ratio),
    .out_overrun_count   (out_overrun_count),
    .out_resampled_count (out_resampled_count)
  );

endmodule

`default_nettype wire

### dv/tb_elastic_stereo_fifo_resampler_core.sv
// ----------------------------------------------------------------------------
// tb_elastic_stereo_fifo_resampler_core
// Drives push, pull, trim and unknown command words into the resampler core
// while a bit-exact predictor tracks ring buffer, depth filter, ratio and
// Hermite state. Every status word is checked field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

// Predicts one status word per command word and holds them until they arrive.
class status_tracker;
  typedef struct {
    bit          acc;
    logic [23:0] left;
    logic [23:0] right;
    bit          disc;
    logic [12:0] fill;
    logic [12:0] peak;
    logic [30:0] ratio;
    logic [31:0] overruns;
    logic [31:0] resampled;
  } status_t;

  status_t pending_status[$];
  logic signed [23:0] left_mem[4096];
  logic signed [23:0] right_mem[4096];
  bit mark_mem[4096];
  int unsigned target;
  longint unsigned wr_ptr, rd_ptr, phase, peak;
  longint ratio, depth_avg, hist_l, hist_r;
  bit hist_ok, gap_pending;
  int unsigned overruns, resampled;
  int errors;
  int checked;

  function new();
    errors = 0;
    checked = 0;
    target = 256;
    wr_ptr = 0;
    rd_ptr = 0;
    phase = 0;
    ratio = 64'sd1 <<< 30;
    depth_avg = longint'(eff_target()) <<< 32;
    hist_l = 0;
    hist_r = 0;
    hist_ok = 0;
    gap_pending = 0;
    peak = eff_target();
    overruns = 0;
    resampled = 0;
  endfunction

  function int unsigned eff_target();
    if (target < 16) return 16;
    if (target > 1024) return 1024;
    return target;
  endfunction

  function longint unsigned fill();
    return (wr_ptr - rd_ptr) & 64'h1FFF;
  endfunction

  function void set_target(int unsigned v);
    target = v & 32'h7FF;
  endfunction

  function longint hermite(longint y0, longint y1, longint y2, longint y3, longint mu);
    longint c0, c1, c2, t, v;
    c0 = -y0 + 3 * y1 - 3 * y2 + y3;
    c1 = 2 * y0 - 5 * y1 + 4 * y2 - y3;
    c2 = y2 - y0;
    t = ((c0 * mu) >>> 20) + c1;
    t = ((t * mu) >>> 20) + c2;
    t = t * mu;
    v = y1 + ((t + (64'sd1 <<< 20)) >>> 21);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v;
  endfunction

  function void note_command(logic [1:0] cmd, logic signed [23:0] il,
                             logic signed [23:0] ir, bit idisc);
    status_t s;
    longint unsigned cnt, cur, nxt, nn, nexp, adv, p;
    longint tgt, diff, dev, desired, y0l, y0r, y1l, y1r, y2l, y2r, y3l, y3r;
    bit cc, nc, n2c;
    s = '{default: 0};
    cnt = fill();
    case (esfr_pkg::cmd_t'(cmd))
      esfr_pkg::CMD_PUSH: begin
        if (cnt >= 4096) begin
          if (overruns != 32'hFFFF_FFFF) overruns++;
        end else begin
          cur = wr_ptr & 4095;
          left_mem[cur] = il;
          right_mem[cur] = ir;
          mark_mem[cur] = idisc;
          wr_ptr = (wr_ptr + 1) & 8191;
          if (cnt + 1 > peak) peak = cnt + 1;
          s.acc = 1;
        end
      end
      esfr_pkg::CMD_PULL: begin
        if (cnt >= 3) begin
          tgt = eff_target();
          diff = longint'(cnt << 32) - depth_avg;
          depth_avg += (diff * 3355) >>> 24;
          dev = (depth_avg - (tgt <<< 32)) / (tgt * 256);
          if (dev > 10737418) dev = 10737418;
          if (dev < -10737418) dev = -10737418;
          desired = (64'sd1 <<< 30) + dev;
          ratio += ((desired - ratio) * 4294967 + (64'sd1 <<< 31)) >>> 32;
          if ((ratio - (64'sd1 <<< 30) > 1073 || (64'sd1 <<< 30) - ratio > 1073)
              && resampled != 32'hFFFF_FFFF)
            resampled++;
          cur = rd_ptr & 4095;
          nxt = (rd_ptr + 1) & 4095;
          nn = (rd_ptr + 2) & 4095;
          cc = mark_mem[cur];
          nc = mark_mem[nxt];
          n2c = mark_mem[nn];
          if (cc) begin
            phase = 0;
            hist_ok = 0;
          end
          s.disc = gap_pending || cc;
          gap_pending = 0;
          mark_mem[cur] = 0;
          y1l = left_mem[cur];
          y1r = right_mem[cur];
          y2l = nc ? y1l : longint'(left_mem[nxt]);
          y2r = nc ? y1r : longint'(right_mem[nxt]);
          y3l = (nc || n2c) ? y2l : longint'(left_mem[nn]);
          y3r = (nc || n2c) ? y2r : longint'(right_mem[nn]);
          y0l = hist_ok ? hist_l : y1l;
          y0r = hist_ok ? hist_r : y1r;
          s.left = 24'(hermite(y0l, y1l, y2l, y3l, longint'(phase >> 10)));
          s.right = 24'(hermite(y0r, y1r, y2r, y3r, longint'(phase >> 10)));
          nexp = phase + (longint'(ratio) & 64'hFFFF_FFFF);
          adv = nexp >> 30;
          phase = nexp & 64'h3FFF_FFFF;
          if (adv + 2 > cnt) begin
            adv = cnt - 2;
            phase = 0;
          end
          for (longint unsigned k = 1; k < adv; k++) begin
            p = (rd_ptr + k) & 4095;
            if (mark_mem[p]) gap_pending = 1;
            mark_mem[p] = 0;
          end
          if (adv > 0) begin
            p = (rd_ptr + adv - 1) & 4095;
            hist_l = left_mem[p];
            hist_r = right_mem[p];
            hist_ok = 1;
          end
          rd_ptr = (rd_ptr + adv) & 8191;
          s.acc = 1;
        end
      end
      esfr_pkg::CMD_TRIM: begin
        tgt = eff_target();
        if (cnt > longint'(tgt)) rd_ptr = (wr_ptr - tgt) & 8191;
        phase = 0;
        ratio = 64'sd1 <<< 30;
        depth_avg = tgt <<< 32;
        hist_ok = 0;
        gap_pending = 0;
        peak = tgt;
        s.acc = 1;
      end
      default: ;
    endcase
    s.fill = 13'(fill());
    s.peak = 13'(peak);
    s.ratio = 31'(ratio);
    s.overruns = overruns;
    s.resampled = resampled;
    pending_status.push_back(s);
  endfunction

  function void field_ok(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
    end
  endfunction

  function void check_status(bit acc, logic [23:0] l, logic [23:0] r, bit disc,
                             logic [12:0] fl, logic [12:0] pk, logic [30:0] rt,
                             logic [31:0] ov, logic [31:0] rs);
    status_t e;
    if (pending_status.size() == 0) begin
      errors++;
      $display("%0t: status word with none expected, expected nothing, got fill %h",
               $time, fl);
      return;
    end
    e = pending_status.pop_front();
    checked++;
    field_ok("accepted", 32'(e.acc), 32'(acc));
    field_ok("left", 32'(e.left), 32'(l));
    field_ok("right", 32'(e.right), 32'(r));
    field_ok("discontinuity", 32'(e.disc), 32'(disc));
    field_ok("fill_level", 32'(e.fill), 32'(fl));
    field_ok("peak_fill", 32'(e.peak), 32'(pk));
    field_ok("resample_ratio", 32'(e.ratio), 32'(rt));
    field_ok("overrun_count", e.overruns, ov);
    field_ok("resampled_count", e.resampled, rs);
  endfunction
endclass

module tb_elastic_stereo_fifo_resampler_core;
  import esfr_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_command = CMD_NOP;
  logic signed [23:0] in_left = '0;
  logic signed [23:0] in_right = '0;
  logic in_discontinuity = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_accepted;
  logic signed [23:0] out_left, out_right;
  logic out_discontinuity;
  logic [12:0] out_fill_level, out_peak_fill;
  logic [30:0] out_resample_ratio;
  logic [31:0] out_overrun_count, out_resampled_count;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  status_tracker book = new();
  int cycles = 0;
  int words_sent = 0;
  int settings_used = 0;
  bit calm = 1'b1;       // no idling on either side while set
  int hold_req = 0;      // bumped to ask the receiver for a long hold
  int hold_seen = 0;
  int hold_left = 0;
  int stall_run = 0;

  elastic_stereo_fifo_resampler_core u_top (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_command, .in_left, .in_right, .in_discontinuity,
    .out_valid, .out_stall, .out_accepted, .out_left, .out_right,
    .out_discontinuity, .out_fill_level, .out_peak_fill, .out_resample_ratio,
    .out_overrun_count, .out_resampled_count,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Note every accepted command word, then check any status word that left.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      book.note_command(in_command, in_left, in_right, in_discontinuity);
    if (rst_n && out_valid && !out_stall)
      book.check_status(out_accepted, out_left, out_right, out_discontinuity,
                        out_fill_level, out_peak_fill, out_resample_ratio,
                        out_overrun_count, out_resampled_count);
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Receiver stall: random runs, plus a long counted hold on request.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 800;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (stall_run > 0) begin
      stall_run <= stall_run - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      stall_run <= pick_gap();
    end
  end

  function automatic logic [23:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 24'h7F_FFFF;
      1: return 24'h80_0000;
      2: return 24'($urandom_range(0, 255)) - 24'd128;
      default: return 24'($urandom);
    endcase
  endfunction

  // Offer one command word and hold it until taken.
  task automatic send_word(cmd_t cmd, logic [23:0] l, logic [23:0] r, bit d);
    int gap;
    in_valid <= 1'b1;
    in_command <= cmd;
    in_left <= l;
    in_right <= r;
    in_discontinuity <= d;
    do @(posedge clk); while (in_stall);
    words_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random(cmd_t cmd);
    send_word(cmd, pick_sample(), pick_sample(), $urandom_range(0, 9) == 0);
  endtask

  // Drain all status words, then write target_fill over APB.
  task automatic write_target(logic [31:0] v);
    @(posedge clk);
    in_valid <= 1'b0;
    while (book.pending_status.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 3'(REG_TARGET) << 2;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    book.set_target(v);
    settings_used++;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic random_phase(int n);
    int r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 52) send_random(CMD_PUSH);
      else if (r < 92) send_random(CMD_PULL);
      else if (r < 97) send_random(CMD_TRIM);
      else send_random(CMD_NOP);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: underrun, unknown command, extremes, marks, trims.
    write_target(0);
    send_word(CMD_PULL, 0, 0, 0);
    send_word(CMD_NOP, 24'h7F_FFFF, 24'h80_0000, 1);
    send_word(CMD_PUSH, 24'h7F_FFFF, 24'h80_0000, 0);
    send_word(CMD_PUSH, 24'h80_0000, 24'h7F_FFFF, 0);
    send_word(CMD_PULL, 0, 0, 0);
    send_word(CMD_PUSH, 24'h7F_FFFF, 24'h80_0000, 1);
    send_word(CMD_PUSH, 24'h00_0000, 24'hFF_FFFF, 0);
    send_word(CMD_PUSH, 24'h55_5555, 24'hAA_AAAA, 1);
    send_word(CMD_PUSH, 24'h2A_AAAA, 24'hD5_5555, 0);
    repeat (5) send_word(CMD_PULL, 0, 0, 0);
    send_word(CMD_TRIM, 0, 0, 0);
    repeat (6) send_random(CMD_PUSH);
    send_word(CMD_PULL, 0, 0, 0);
    send_word(CMD_TRIM, 0, 0, 0);

    // Fill past capacity so pushes overrun, then trim back.
    write_target(2047);
    repeat (4110) send_random(CMD_PUSH);
    repeat (20) send_random(CMD_PULL);
    send_random(CMD_TRIM);
    repeat (30) send_random(CMD_PULL);

    // Random phases over several targets; one has a long receiver hold.
    calm = 1'b0;
    write_target(16);
    hold_req++;
    random_phase(250);
    write_target(1024);
    repeat (60) send_random(CMD_PUSH);
    random_phase(250);
    calm = 1'b1;
    write_target(256);
    random_phase(250);
    calm = 1'b0;
    write_target($urandom_range(0, 2047));
    random_phase(250);
    write_target($urandom_range(17, 1023));
    random_phase(250);

    @(posedge clk);
    in_valid <= 1'b0;
    while (book.pending_status.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("ran %0d command words under %0d target settings, %0d status words checked",
             words_sent, settings_used, book.checked);
    $display("reached buffer overflow, underrun, trims and drift-steered pulls");
    if (book.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

`default_nettype wire
